// ===== design/slcd_pkg.sv =====
package slcd_pkg;

  // Command codes
  localparam logic [2:0] OP_CLEAR_ALL = 3'd0;
  localparam logic [2:0] OP_SET_SEG   = 3'd1;
  localparam logic [2:0] OP_CLR_SEG   = 3'd2;
  localparam logic [2:0] OP_DIGIT     = 3'd3;
  localparam logic [2:0] OP_SHOW      = 3'd4;

  localparam int NUM_WORDS = 8;
  localparam int NUM_DIGS  = 6;

  // Input request as it arrives on the port
  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         segment;
    logic [3:0]         digit;
    logic [3:0]         position;
    logic signed [23:0] number;
  } in_t;

  // Result: whole segment memory
  typedef struct packed {
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [15:0] word4;
    logic [15:0] word5;
    logic [15:0] word6;
    logic [15:0] word7;
  } out_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  segment;
    logic [3:0]  digit;
    logic [3:0]  position;
    logic        neg;
    logic [23:0] mag;
  } cmd_t;

endpackage

// ===== design/slcd_front.sv =====
module slcd_front
  import slcd_pkg::*;
(
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic push_valid,
  input  logic push_full,
  output cmd_t push_data
);

  // Handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_stall   = push_full;

  // Sign and magnitude of the number for the show command
  logic        neg;
  logic [23:0] mag;
  always_comb begin
    neg = in_data.number[23];
    if (neg) begin
      mag = 24'(~in_data.number) + 24'd1;
    end else begin
      mag = in_data.number;
    end
  end

  // Build the command; fields the op does not use are zeroed
  always_comb begin
    push_data          = '0;
    push_data.op       = in_data.op;
    case (in_data.op)
      OP_SET_SEG, OP_CLR_SEG: begin
        push_data.segment = in_data.segment;
      end
      OP_DIGIT: begin
        push_data.digit    = in_data.digit;
        push_data.position = in_data.position;
      end
      OP_SHOW: begin
        push_data.neg = neg;
        push_data.mag = mag;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/slcd_queue.sv =====
module slcd_queue
  import slcd_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_full,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_full = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/slcd_back.sv =====
module slcd_back
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] minus_segment,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  typedef logic [NUM_WORDS-1:0][15:0] mem_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_WR,
    S_DONE
  } state_t;

  // ceil(2^27 / 10); exact quotient for values below 2^26
  localparam logic [23:0] RECIP10 = 24'd13421773;

  // Board fonts
  function automatic logic [7:0] big_font(input logic [3:0] d);
    case (d)
      4'd0: big_font = 8'hEB;
      4'd1: big_font = 8'h60;
      4'd2: big_font = 8'hC7;
      4'd3: big_font = 8'hE5;
      4'd4: big_font = 8'h6C;
      4'd5: big_font = 8'hAD;
      4'd6: big_font = 8'hAF;
      4'd7: big_font = 8'hE0;
      4'd8: big_font = 8'hEF;
      4'd9: big_font = 8'hED;
      default: big_font = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] small_font(input logic [3:0] d);
    case (d)
      4'd0: small_font = 8'hD7;
      4'd1: small_font = 8'h06;
      4'd2: small_font = 8'hE3;
      4'd3: small_font = 8'hA7;
      4'd4: small_font = 8'h36;
      4'd5: small_font = 8'hB5;
      4'd6: small_font = 8'hF5;
      4'd7: small_font = 8'h07;
      4'd8: small_font = 8'hF7;
      4'd9: small_font = 8'hB7;
      default: small_font = 8'h00;
    endcase
  endfunction

  // Position map: word, keep mask, shift; position 2 is split across two words
  function automatic mem_t digit_write(input mem_t m, input logic [3:0] d,
                                       input logic [3:0] pos);
    mem_t        r;
    logic [7:0]  pat;
    logic [2:0]  w;
    logic [15:0] keep;
    logic [3:0]  sh;
    r    = m;
    pat  = (pos >= 4'd7) ? small_font(d) : big_font(d);
    w    = 3'd0;
    keep = 16'hFFFF;
    sh   = 4'd0;
    case (pos)
      4'd1:  begin w = 3'd0; keep = 16'hF10F; sh = 4'd4; end
      4'd3:  begin w = 3'd1; keep = 16'hF10F; sh = 4'd4; end
      4'd4:  begin w = 3'd3; keep = 16'hFF10; sh = 4'd0; end
      4'd5:  begin w = 3'd3; keep = 16'h10FF; sh = 4'd8; end
      4'd6:  begin w = 3'd4; keep = 16'hFF10; sh = 4'd0; end
      4'd7:  begin w = 3'd6; keep = 16'hFF08; sh = 4'd0; end
      4'd8:  begin w = 3'd6; keep = 16'h08FF; sh = 4'd8; end
      4'd9:  begin w = 3'd7; keep = 16'hFF08; sh = 4'd0; end
      4'd10: begin w = 3'd7; keep = 16'h08FF; sh = 4'd8; end
      default: begin end
    endcase
    if (pos == 4'd2) begin
      r[0] = (m[0] & 16'h0FFF) | {pat[3:0], 12'h000};
      r[1] = (m[1] & 16'hFFF1) | {12'h000, pat[7:4]};
    end else if (pos >= 4'd1 && pos <= 4'd10) begin
      r[w] = (m[w] & keep) | (16'(pat) << sh);
    end
    return r;
  endfunction

  state_t      state;
  mem_t        mem;
  mem_t        mem_next;
  logic [23:0] div_val;
  logic [2:0]  cnt;
  logic        lead;
  logic [3:0]  digs [NUM_DIGS];

  // Divide by ten through the reciprocal
  logic [47:0] prod;
  logic [20:0] quot;
  logic [23:0] rem_full;
  logic [3:0]  rem;
  assign prod     = 48'(div_val) * 48'(RECIP10);
  assign quot     = prod[47:27];
  assign rem_full = div_val - {quot, 3'b000} - {2'b00, quot, 1'b0};
  assign rem      = rem_full[3:0];

  // Digit for the current write step, with leading zero blanking
  logic [3:0] wr_dig_raw;
  logic [3:0] wr_dig;
  logic       wr_blank;
  logic [3:0] wr_pos;
  assign wr_dig_raw = digs[3'(NUM_DIGS - 1) - cnt];
  assign wr_blank   = lead && (cnt < 3'd4) && (wr_dig_raw == 4'd0);
  assign wr_dig     = wr_blank ? 4'd10 : wr_dig_raw;
  assign wr_pos     = {1'b0, cnt} + 4'd1;

  assign pop_ready = (state == S_IDLE);

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // Memory update for the step in progress
  always_comb begin
    mem_next = mem;
    if (state == S_IDLE && pop_valid) begin
      case (pop_data.op)
        OP_CLEAR_ALL: mem_next = '0;
        OP_SET_SEG:
          mem_next[pop_data.segment[6:4]] =
            mem[pop_data.segment[6:4]] | (16'd1 << pop_data.segment[3:0]);
        OP_CLR_SEG:
          mem_next[pop_data.segment[6:4]] =
            mem[pop_data.segment[6:4]] & ~(16'd1 << pop_data.segment[3:0]);
        OP_DIGIT: mem_next = digit_write(mem, pop_data.digit, pop_data.position);
        OP_SHOW: begin
          if (pop_data.neg) begin
            mem_next[minus_segment[6:4]] =
              mem[minus_segment[6:4]] | (16'd1 << minus_segment[3:0]);
          end else begin
            mem_next[minus_segment[6:4]] =
              mem[minus_segment[6:4]] & ~(16'd1 << minus_segment[3:0]);
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_WR) begin
      mem_next = digit_write(mem, wr_dig, wr_pos);
    end
  end

  // Sequencer, segment memory and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mem       <= '0;
      cnt       <= '0;
      lead      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mem <= mem_next;
      // Result valid: set on load, dropped once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            if (pop_data.op == OP_SHOW) begin
              div_val <= pop_data.mag;
              cnt     <= '0;
              state   <= S_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DIV: begin
          digs[cnt] <= rem;
          div_val   <= 24'(quot);
          if (cnt == 3'(NUM_DIGS - 1)) begin
            cnt   <= '0;
            lead  <= 1'b1;
            state <= S_WR;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_WR: begin
          if (!wr_blank) begin
            lead <= 1'b0;
          end
          if (cnt == 3'(NUM_DIGS - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_data.word0 <= mem[0];
            out_data.word1 <= mem[1];
            out_data.word2 <= mem[2];
            out_data.word3 <= mem[3];
            out_data.word4 <= mem[4];
            out_data.word5 <= mem[5];
            out_data.word6 <= mem[6];
            out_data.word7 <= mem[7];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/segment_lcd_number_buffer.sv =====
// Segment LCD number buffer.
// Input channel (in_valid / in_stall / in_data) takes one command request:
// clear all, set segment, clear segment, write digit, or show signed number.
// Output channel (out_valid / out_stall / out_data) returns all eight 16-bit
// words of the segment memory after each request, one result per request.
// cfg_wr_en / cfg_wr_data write the minus-sign segment index; write it only
// while no request is in flight.
// A small command queue sits between the front and the execution sequencer,
// so requests are taken while the sequencer is busy until the queue fills.
// In the sequencer, clear, set, clear-segment and digit requests update the
// memory when popped, then load the output register; show-number runs a
// minus-sign step, a divide-by-ten step for each of the six digits, six
// digit writes and an output load.
// Reset clears the segment memory, the minus-sign index, the queue and
// out_valid. While out_stall is high the result holds; the sequencer
// finishes the next request and waits, then the queue fills and in_stall rises.
module segment_lcd_number_buffer
  import slcd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  logic [6:0] minus_segment;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      minus_segment <= '0;
    end else if (cfg_wr_en) begin
      minus_segment <= cfg_wr_data;
    end
  end

  logic push_valid;
  logic push_full;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  slcd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  slcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  slcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .minus_segment (minus_segment),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
